// ===== src/irenc_pkg.sv =====
// Package for the integer to Roman numeral encoder: widths, letter codes,
// digit tables and the command/status structs shared by its modules.
// No dependencies.
package irenc_pkg;

   localparam int VALUE_W  = 12;
   localparam int LETTER_W = 3;
   localparam int DIGITS   = 4;
   localparam int BCD_W    = 4 * DIGITS;
   localparam int CNT_W    = 4;
   localparam int POS_W    = 2;
   localparam int IDX_W    = 2;
   localparam int LEN_W    = 3;

   localparam logic [VALUE_W-1:0] MAX_VALID = 12'd3999;

   localparam logic [LETTER_W-1:0] LET_I = 3'd0;
   localparam logic [LETTER_W-1:0] LET_V = 3'd1;
   localparam logic [LETTER_W-1:0] LET_X = 3'd2;
   localparam logic [LETTER_W-1:0] LET_L = 3'd3;
   localparam logic [LETTER_W-1:0] LET_C = 3'd4;
   localparam logic [LETTER_W-1:0] LET_D = 3'd5;
   localparam logic [LETTER_W-1:0] LET_M = 3'd6;

   // Which of the three letters of a decade a position within a digit uses.
   localparam logic [1:0] SEL_ONE  = 2'd0;
   localparam logic [1:0] SEL_FIVE = 2'd1;
   localparam logic [1:0] SEL_TEN  = 2'd2;

   // Digit positions, most significant first.
   localparam logic [POS_W-1:0] POS_THOU = 2'd0;
   localparam logic [POS_W-1:0] POS_HUND = 2'd1;
   localparam logic [POS_W-1:0] POS_TENS = 2'd2;
   localparam logic [POS_W-1:0] POS_UNIT = 2'd3;

   typedef struct packed {
      logic load;
      logic shift;
      logic next_letter;
      logic next_digit;
      logic emit_letter;
      logic emit_error;
   } irenc_cmd_type;

   typedef struct packed {
      logic value_bad;
      logic digit_empty;
      logic digit_end;
      logic final_letter;
   } irenc_status_type;

   // Number of letters that one decimal digit takes.
   function automatic logic [LEN_W-1:0] digit_len(input logic [3:0] d);
      logic [LEN_W-1:0] len;
      unique case (d)
         4'd1:    len = 3'd1;
         4'd2:    len = 3'd2;
         4'd3:    len = 3'd3;
         4'd4:    len = 3'd2;
         4'd5:    len = 3'd1;
         4'd6:    len = 3'd2;
         4'd7:    len = 3'd3;
         4'd8:    len = 3'd4;
         4'd9:    len = 3'd2;
         default: len = 3'd0;
      endcase
      return len;
   endfunction

   // Letter class at position j within the letters of digit d.
   function automatic logic [1:0] digit_sel(input logic [3:0] d, input logic [IDX_W-1:0] j);
      logic [1:0] sel;
      if (d == 4'd9) begin
         sel = (j == 2'd0) ? SEL_ONE : SEL_TEN;
      end else if (d == 4'd4) begin
         sel = (j == 2'd0) ? SEL_ONE : SEL_FIVE;
      end else if (d >= 4'd5) begin
         sel = (j == 2'd0) ? SEL_FIVE : SEL_ONE;
      end else begin
         sel = SEL_ONE;
      end
      return sel;
   endfunction

   // Letter code for a letter class at a digit position.
   function automatic logic [LETTER_W-1:0] letter_of(input logic [POS_W-1:0] pos,
                                                     input logic [1:0] sel);
      logic [LETTER_W-1:0] one;
      logic [LETTER_W-1:0] five;
      logic [LETTER_W-1:0] ten;
      logic [LETTER_W-1:0] let_code;
      unique case (pos)
         POS_THOU: begin one = LET_M; five = LET_M; ten = LET_M; end
         POS_HUND: begin one = LET_C; five = LET_D; ten = LET_M; end
         POS_TENS: begin one = LET_X; five = LET_L; ten = LET_C; end
         default:  begin one = LET_I; five = LET_V; ten = LET_X; end
      endcase
      unique case (sel)
         SEL_FIVE: let_code = five;
         SEL_TEN:  let_code = ten;
         default:  let_code = one;
      endcase
      return let_code;
   endfunction

endpackage

// ===== src/irenc_datapath.sv =====
// Datapath of the Roman numeral encoder: binary to BCD shift converter,
// digit/letter pointers and the result registers. Depends on irenc_pkg.
module irenc_datapath (
   input  logic                              clock,
   input  logic                              reset,
   input  logic [irenc_pkg::VALUE_W-1:0]     req_value,
   input  irenc_pkg::irenc_cmd_type          cmd,
   output irenc_pkg::irenc_status_type       status,
   output logic                              rsp_strobe,
   output logic [irenc_pkg::LETTER_W-1:0]    rsp_letter,
   output logic                              rsp_last,
   output logic                              rsp_error
);

   logic [irenc_pkg::VALUE_W-1:0]  bin_ff, bin_in;
   logic [irenc_pkg::BCD_W-1:0]    bcd_ff, bcd_in;
   logic [irenc_pkg::BCD_W-1:0]    bcd_adj;
   logic [irenc_pkg::POS_W-1:0]    pos_ff, pos_in;
   logic [irenc_pkg::IDX_W-1:0]    idx_ff, idx_in;
   logic                           strobe_ff, strobe_in;
   logic [irenc_pkg::LETTER_W-1:0] letter_ff, letter_in;
   logic                           last_ff, last_in;
   logic                           error_ff, error_in;

   logic [3:0]                     cur_digit;
   logic [irenc_pkg::LEN_W-1:0]    cur_len;
   logic                           rest_zero;
   logic [irenc_pkg::LETTER_W-1:0] cur_letter;

   // Add-3 correction on every BCD nibble before the shift.
   always_comb begin
      for (int n = 0; n < irenc_pkg::DIGITS; n++) begin
         bcd_adj[4*n +: 4] = (bcd_ff[4*n +: 4] >= 4'd5) ? bcd_ff[4*n +: 4] + 4'd3
                                                         : bcd_ff[4*n +: 4];
      end
   end

   always_comb begin
      unique case (pos_ff)
         irenc_pkg::POS_THOU: begin
            cur_digit = bcd_ff[15:12];
            rest_zero = (bcd_ff[11:0] == 12'd0);
         end
         irenc_pkg::POS_HUND: begin
            cur_digit = bcd_ff[11:8];
            rest_zero = (bcd_ff[7:0] == 8'd0);
         end
         irenc_pkg::POS_TENS: begin
            cur_digit = bcd_ff[7:4];
            rest_zero = (bcd_ff[3:0] == 4'd0);
         end
         default: begin
            cur_digit = bcd_ff[3:0];
            rest_zero = 1'b1;
         end
      endcase
   end

   assign cur_len    = irenc_pkg::digit_len(cur_digit);
   assign cur_letter = irenc_pkg::letter_of(pos_ff, irenc_pkg::digit_sel(cur_digit, idx_ff));

   assign status.value_bad    = (req_value == '0) || (req_value > irenc_pkg::MAX_VALID);
   assign status.digit_empty  = (cur_len == '0);
   assign status.digit_end    = ((irenc_pkg::LEN_W'(idx_ff) + 3'd1) == cur_len);
   assign status.final_letter = status.digit_end && rest_zero;

   always_comb begin
      bin_in = bin_ff;
      bcd_in = bcd_ff;
      pos_in = pos_ff;
      idx_in = idx_ff;
      if (cmd.load) begin
         bin_in = req_value;
         bcd_in = '0;
         pos_in = irenc_pkg::POS_THOU;
         idx_in = '0;
      end else if (cmd.shift) begin
         bin_in = {bin_ff[irenc_pkg::VALUE_W-2:0], 1'b0};
         bcd_in = {bcd_adj[irenc_pkg::BCD_W-2:0], bin_ff[irenc_pkg::VALUE_W-1]};
      end else if (cmd.next_digit) begin
         pos_in = pos_ff + 2'd1;
         idx_in = '0;
      end else if (cmd.next_letter) begin
         idx_in = idx_ff + 2'd1;
      end
   end

   always_comb begin
      strobe_in = cmd.emit_letter || cmd.emit_error;
      letter_in = cmd.emit_error ? irenc_pkg::LET_I : cur_letter;
      last_in   = cmd.emit_error || status.final_letter;
      error_in  = cmd.emit_error;
   end

   always_ff @(posedge clock) begin
      bin_ff    <= bin_in;
      bcd_ff    <= bcd_in;
      pos_ff    <= pos_in;
      idx_ff    <= idx_in;
      letter_ff <= letter_in;
      last_ff   <= last_in;
      error_ff  <= error_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= strobe_in;
      end
   end

   assign rsp_strobe = strobe_ff;
   assign rsp_letter = letter_ff;
   assign rsp_last   = last_ff;
   assign rsp_error  = error_ff;

endmodule

// ===== src/irenc_ctrl.sv =====
// Controller of the Roman numeral encoder: sequences loading, BCD
// conversion and letter emission. Depends on irenc_pkg.
module irenc_ctrl (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  irenc_pkg::irenc_status_type  status,
   output irenc_pkg::irenc_cmd_type     cmd
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_CONV = 2'd1;
   localparam logic [1:0] ST_EMIT = 2'd2;

   logic [1:0]                  state_ff, state_in;
   logic [irenc_pkg::CNT_W-1:0] cnt_ff, cnt_in;

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               if (status.value_bad) begin
                  cmd.emit_error = 1'b1;
               end else begin
                  cmd.load = 1'b1;
                  cnt_in   = '0;
                  state_in = ST_CONV;
               end
            end
         end
         ST_CONV: begin
            cmd.shift = 1'b1;
            cnt_in    = cnt_ff + 4'd1;
            if (cnt_ff == irenc_pkg::CNT_W'(irenc_pkg::VALUE_W - 1)) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (status.digit_empty) begin
               cmd.next_digit = 1'b1;
            end else begin
               cmd.emit_letter = 1'b1;
               if (status.final_letter) begin
                  state_in = ST_IDLE;
               end else if (status.digit_end) begin
                  cmd.next_digit = 1'b1;
               end else begin
                  cmd.next_letter = 1'b1;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   assign busy = (state_ff != ST_IDLE);

endmodule

// ===== src/integer_to_roman_encoder_top.sv =====
// Roman numeral encoder, top level: a valid value (1 to 3999) is loaded, converted to BCD by shifting,
// then emitted one letter at a time, with an extra step for each leading or inner zero digit; the
// longest numeral (3888) has 15 letters. A new value is accepted only when idle, after the previous
// one has emitted its final letter.
// The receiver cannot stall; each letter shows on the rsp_ ports for one cycle under rsp_strobe.
// A value of 0 or above 3999 gives one error result the next cycle and leaves busy low.
// Reset is synchronous and active high; it returns the controller to idle and clears the strobe.
module integer_to_roman_encoder_top (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   output logic                             busy,
   input  logic [irenc_pkg::VALUE_W-1:0]    req_value,
   output logic                             rsp_strobe,
   output logic [irenc_pkg::LETTER_W-1:0]   rsp_letter,
   output logic                             rsp_last,
   output logic                             rsp_error
);

   // Commands flow from the controller to the datapath; status flows back.
   irenc_pkg::irenc_cmd_type    cmd;
   irenc_pkg::irenc_status_type status;

   // The controller owns the sequence: it accepts a transaction when idle, walks the
   // twelve shift steps of the binary to BCD conversion and then steps through the
   // digits, skipping empty ones and stopping on the letter flagged as final.
   irenc_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .busy   (busy),
      .status (status),
      .cmd    (cmd)
   );

   // The datapath holds the value, its BCD digits, the digit and letter pointers
   // and the registered result ports.
   irenc_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .req_value  (req_value),
      .cmd        (cmd),
      .status     (status),
      .rsp_strobe (rsp_strobe),
      .rsp_letter (rsp_letter),
      .rsp_last   (rsp_last),
      .rsp_error  (rsp_error)
   );

endmodule

// ===== dv/testbench.sv =====
// Self-checking testbench for integer_to_roman_encoder_top: directed and random values,
// with every letter checked against a spelled-out numeral or the in-bench predictor.
// Depends on irenc_pkg and the encoder top level; needs no files or arguments.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   // One letter of a numeral as it is expected on the rsp_ ports.
   typedef struct packed {
      logic [irenc_pkg::LETTER_W-1:0] letter;
      logic                           last;
      logic                           error;
   } roman_letter_type;

   // A directed row: the value, and its numeral spelled out where it is obvious.
   // An empty spelling hands the row to the predictor; a dash marks an out-of-range value.
   typedef struct {
      logic [irenc_pkg::VALUE_W-1:0] value;
      string                         spelled;
   } directed_row_type;

   // The letter field carries no meaning on an error result and is held at zero.
   localparam logic [irenc_pkg::LETTER_W-1:0] NO_LETTER = '0;

   // Covers any tail of work in the block after the last owed letter.
   localparam int DRAIN_CYCLES = 40;
   // About 230 items, some with a sender gap before them, make up the run; the limit
   // leaves a wide margin above its length.
   localparam int CYCLE_LIMIT  = 200000;
   localparam int RANDOM_ITEMS = 207;

   logic                             clock;
   logic                             reset;
   logic                             start;
   logic                             busy;
   logic [irenc_pkg::VALUE_W-1:0]    req_value;
   logic                             rsp_strobe;
   logic [irenc_pkg::LETTER_W-1:0]   rsp_letter;
   logic                             rsp_last;
   logic                             rsp_error;

   // Letters still owed by the block, oldest first, across all accepted transactions.
   roman_letter_type pending_letters[$];
   int               mismatches;
   int               cycle_count;
   int               idle_percent;

   integer_to_roman_encoder_top dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_value  (req_value),
      .rsp_strobe (rsp_strobe),
      .rsp_letter (rsp_letter),
      .rsp_last   (rsp_last),
      .rsp_error  (rsp_error)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Append one ordinary letter; the last flag is set once the whole numeral is known.
   function automatic void queue_letter(input logic [irenc_pkg::LETTER_W-1:0] code);
      pending_letters.push_back('{code, 1'b0, 1'b0});
   endfunction

   // One decimal digit written with the one, five and ten letters of its decade.
   // The digits 4 and 9 take the subtractive pairs; the others are an optional
   // five followed by up to three ones.
   function automatic void append_digit_letters(input int d,
                                                input logic [irenc_pkg::LETTER_W-1:0] one,
                                                input logic [irenc_pkg::LETTER_W-1:0] five,
                                                input logic [irenc_pkg::LETTER_W-1:0] ten);
      int reps;
      reps = d;
      if (d == 9) begin
         queue_letter(one);
         queue_letter(ten);
      end else if (d == 4) begin
         queue_letter(one);
         queue_letter(five);
      end else begin
         if (d >= 5) begin
            queue_letter(five);
            reps = d - 5;
         end
         repeat (reps) queue_letter(one);
      end
   endfunction

   // Predicts the full letter sequence of one value and appends it to the
   // expected queue. Zero and anything above 3999 produce a single error result.
   function automatic void predict_numeral(input logic [irenc_pkg::VALUE_W-1:0] v);
      int n;
      n = int'(v);
      if (v == '0 || v > irenc_pkg::MAX_VALID) begin
         pending_letters.push_back('{NO_LETTER, 1'b1, 1'b1});
      end else begin
         repeat (n / 1000) queue_letter(irenc_pkg::LET_M);
         append_digit_letters((n / 100) % 10, irenc_pkg::LET_C, irenc_pkg::LET_D,
                              irenc_pkg::LET_M);
         append_digit_letters((n / 10) % 10, irenc_pkg::LET_X, irenc_pkg::LET_L,
                              irenc_pkg::LET_C);
         append_digit_letters(n % 10, irenc_pkg::LET_I, irenc_pkg::LET_V,
                              irenc_pkg::LET_X);
         pending_letters[pending_letters.size() - 1].last = 1'b1;
      end
   endfunction

   // Offers one value and holds start until the block takes it. The caller decides
   // whether start drops afterwards, so a back-to-back transaction keeps start high
   // without a drop and rise in the same time step.
   task automatic send_value(input logic [irenc_pkg::VALUE_W-1:0] v, input string spelled);
      int i;
      start     <= 1'b1;
      req_value <= v;
      do @(posedge clock); while (busy !== 1'b0);
      // The transaction was taken at this edge; record what it must produce.
      if (spelled.len() == 0) begin
         predict_numeral(v);
      end else if (spelled == "-") begin
         pending_letters.push_back('{NO_LETTER, 1'b1, 1'b1});
      end else begin
         for (i = 0; i < spelled.len(); i++) begin
            case (spelled[i])
               "I": queue_letter(irenc_pkg::LET_I);
               "V": queue_letter(irenc_pkg::LET_V);
               "X": queue_letter(irenc_pkg::LET_X);
               "L": queue_letter(irenc_pkg::LET_L);
               "C": queue_letter(irenc_pkg::LET_C);
               "D": queue_letter(irenc_pkg::LET_D);
               default: queue_letter(irenc_pkg::LET_M);
            endcase
         end
         pending_letters[pending_letters.size() - 1].last = 1'b1;
      end
   endtask

   // Waits until every owed letter has come out, then lets the block settle.
   task automatic drain_letters();
      while (pending_letters.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Random gap before the next transaction. Gap lengths span the whole life of an
   // item in the block, so the next start lands on every phase of its work.
   task automatic maybe_idle();
      if ($urandom_range(0, 99) < idle_percent) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 32)) @(posedge clock);
      end
   endtask

   // Random values: mostly well-formed numerals, a slice of long ones built from
   // digits 3, 7 and 8, and a few out-of-range values at both ends.
   function automatic logic [irenc_pkg::VALUE_W-1:0] random_value();
      int pick;
      int long_digits[3];
      logic [irenc_pkg::VALUE_W-1:0] v;
      long_digits = '{3, 7, 8};
      pick = $urandom_range(0, 99);
      if (pick < 5) begin
         v = '0;
      end else if (pick < 10) begin
         v = irenc_pkg::VALUE_W'($urandom_range(4000, 4095));
      end else if (pick < 30) begin
         v = irenc_pkg::VALUE_W'($urandom_range(0, 3) * 1000
                                 + long_digits[$urandom_range(0, 2)] * 100
                                 + long_digits[$urandom_range(0, 2)] * 10
                                 + long_digits[$urandom_range(0, 2)]);
      end else begin
         v = irenc_pkg::VALUE_W'($urandom_range(1, 3999));
      end
      return v;
   endfunction

   // Result checker. Every strobed letter is taken at the edge that ends its cycle
   // and compared with the oldest expectation, field by field.
   always @(posedge clock) begin
      roman_letter_type want;
      if (!reset && rsp_strobe !== 1'b0) begin
         if (pending_letters.size() == 0) begin
            $error("unexpected letter: letter %0d, last %0b, error %0b",
                   rsp_letter, rsp_last, rsp_error);
            mismatches++;
         end else begin
            want = pending_letters.pop_front();
            if (rsp_letter !== want.letter) begin
               $error("letter: expected %0d, got %0d", want.letter, rsp_letter);
               mismatches++;
            end
            if (rsp_last !== want.last) begin
               $error("last: expected %0b, got %0b", want.last, rsp_last);
               mismatches++;
            end
            if (rsp_error !== want.error) begin
               $error("error: expected %0b, got %0b", want.error, rsp_error);
               mismatches++;
            end
         end
      end
   end

   // Watchdog: a hung handshake or a lost letter ends the run here.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("testbench NOT OK");
         $finish;
      end
   end

   initial begin
      directed_row_type directed[];
      int i;
      int phase;

      reset        = 1'b1;
      start        = 1'b0;
      req_value    = '0;
      mismatches   = 0;
      cycle_count  = 0;
      idle_percent = 0;

      // Extremes of the field, each letter on its own, each subtractive pair, the longest
      // numeral, the out-of-range values back to back, and values left to the predictor.
      directed = '{
         '{12'd0,    "-"},
         '{12'd4000, "-"},
         '{12'd4095, "-"},
         '{12'd1,    "I"},
         '{12'd5,    "V"},
         '{12'd10,   "X"},
         '{12'd50,   "L"},
         '{12'd100,  "C"},
         '{12'd500,  "D"},
         '{12'd1000, "M"},
         '{12'd4,    "IV"},
         '{12'd9,    "IX"},
         '{12'd40,   "XL"},
         '{12'd90,   "XC"},
         '{12'd400,  "CD"},
         '{12'd900,  "CM"},
         '{12'd3000, "MMM"},
         '{12'd3999, "MMMCMXCIX"},
         '{12'd3888, "MMMDCCCLXXXVIII"},
         '{12'd0,    "-"},
         '{12'd2048, ""},
         '{12'd1365, ""},
         '{12'd2730, ""}
      };

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Directed rows go in back to back, with no gaps.
      for (i = 0; i < directed.size(); i++) begin
         send_value(directed[i].value, directed[i].spelled);
      end

      // Hold the sender off until the block has delivered everything it owes.
      start <= 1'b0;
      drain_letters();

      // Three random phases: a light sender gap rate, a heavy one, then none.
      for (phase = 0; phase < 3; phase++) begin
         case (phase)
            0:       idle_percent = 21;
            1:       idle_percent = 47;
            default: idle_percent = 0;
         endcase
         for (i = 0; i < RANDOM_ITEMS / 3; i++) begin
            maybe_idle();
            send_value(random_value(), "");
         end
      end

      start <= 1'b0;
      drain_letters();

      if (mismatches == 0) begin
         $display("testbench OK");
      end else begin
         $display("testbench NOT OK");
      end
      $finish;
   end

endmodule
